@@ hdl/periodic_task_tick_scheduler_unit_assert.svh @@
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define PTTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication
`define PTTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

@@ hdl/ptts_pkg.sv @@
package ptts_pkg;

   localparam int TIME_W = 16;
   localparam int INDEX_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 2'd1;

   localparam logic POLICY_RM = 1'b0;
   localparam logic POLICY_EDF = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic tick_start;
      logic issue;
      logic eval;
      logic finish;
      logic reply;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic req_load;
   } dp_status_type;

endpackage

@@ hdl/periodic_task_tick_scheduler_unit.sv @@
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_type, task_index, exec_time, period, deadline
// rsp       out        rsp_valid / rsp_stall  load_ack, busy_res, running_task
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A load item goes straight to the reply state; a tick walks the n active entries (n at most
// TASKS) over the task memories: one entry read per cycle, each evaluated and written back
// in the cycle after its read, then a finish step charges the granted entry.
// Reset is synchronous; per-entry flag bits give the reset and restart values at once,
// so there is no clearing pass. csr_ready is always high.
// A new item is taken while the previous result still waits in the output register;
// its result then waits until rsp_stall drops.
module periodic_task_tick_scheduler_unit #(
   parameter int TASKS = 16,
   parameter int TICK_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [ptts_pkg::INDEX_W-1:0]     req_task_index,
   input  logic [ptts_pkg::TIME_W-1:0]      req_exec_time,
   input  logic [ptts_pkg::TIME_W-1:0]      req_period_ticks,
   input  logic [ptts_pkg::TIME_W-1:0]      req_deadline_ticks,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_load_ack,
   output logic                             rsp_busy_res,
   output logic [ptts_pkg::INDEX_W-1:0]     rsp_running_task,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ptts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ptts_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ptts_pkg::*;

   localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int CNT_W = $clog2(TASKS + 1);
   localparam int DL_W = (TICK_BITS + 2 > 18) ? TICK_BITS + 2 : 18;

   ctl_cmd_type cmd;
   dp_status_type status;
   logic [IDX_W-1:0] rd_idx;
   logic [CNT_W-1:0] n_active;

   assign csr_ready = 1'b1;

   ptts_ctrl #(
      .IDX_W(IDX_W),
      .CNT_W(CNT_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .n_active(n_active),
      .cmd(cmd),
      .rd_idx(rd_idx)
   );

   ptts_dpath #(
      .TASKS(TASKS),
      .TICK_BITS(TICK_BITS),
      .IDX_W(IDX_W),
      .CNT_W(CNT_W),
      .DL_W(DL_W)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .rd_idx(rd_idx),
      .n_active(n_active),
      .csr_write(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_type(req_type),
      .req_task_index(req_task_index),
      .req_exec_time(req_exec_time),
      .req_period_ticks(req_period_ticks),
      .req_deadline_ticks(req_deadline_ticks),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_load_ack(rsp_load_ack),
      .rsp_busy_res(rsp_busy_res),
      .rsp_running_task(rsp_running_task)
   );

endmodule

@@ hdl/ptts_ctrl.sv @@
`include "periodic_task_tick_scheduler_unit_assert.svh"

module ptts_ctrl #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ptts_pkg::dp_status_type status,
   input  logic [CNT_W-1:0]      n_active,
   output ptts_pkg::ctl_cmd_type cmd,
   output logic [IDX_W-1:0]      rd_idx
);
   import ptts_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic eval_valid_ff, eval_valid_in;
   logic more;

   assign more = issue_cnt_ff < n_active;
   assign rd_idx = issue_cnt_ff[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.req_load ? ST_REPLY : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!more && !eval_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_REPLY;
         ST_REPLY: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid && status.req_load;
            cmd.tick_start = req_valid && !status.req_load;
         end
         ST_SCAN: cmd.issue = more;
         ST_FINISH: cmd.finish = 1'b1;
         ST_REPLY: cmd.reply = status.out_free;
         default: cmd = '0;
      endcase
      cmd.eval = eval_valid_ff;
   end

   always_comb begin
      issue_cnt_in = issue_cnt_ff;
      if (cmd.tick_start) begin
         issue_cnt_in = '0;
      end else if (cmd.issue) begin
         issue_cnt_in = issue_cnt_ff + CNT_W'(1);
      end
      eval_valid_in = cmd.issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_cnt_ff <= '0;
         eval_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_cnt_ff <= issue_cnt_in;
         eval_valid_ff <= eval_valid_in;
      end
   end

   `PTTS_ASSERT_NOW(a_drained, clock, reset, state_ff == ST_FINISH, !eval_valid_ff)
   `PTTS_ASSERT_NEXT(a_tick_start, clock, reset, cmd.tick_start, state_ff == ST_SCAN && issue_cnt_ff == '0)
   `PTTS_ASSERT_NEXT(a_eval_follows, clock, reset, cmd.issue, cmd.eval)

endmodule

@@ hdl/ptts_dpath.sv @@
module ptts_dpath #(
   parameter int TASKS = 16,
   parameter int TICK_BITS = 16,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5,
   parameter int DL_W = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ptts_pkg::ctl_cmd_type               cmd,
   output ptts_pkg::dp_status_type             status,
   input  logic [IDX_W-1:0]                    rd_idx,
   output logic [CNT_W-1:0]                    n_active,
   input  logic                                csr_write,
   input  logic [ptts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_type,
   input  logic [ptts_pkg::INDEX_W-1:0]        req_task_index,
   input  logic [ptts_pkg::TIME_W-1:0]         req_exec_time,
   input  logic [ptts_pkg::TIME_W-1:0]         req_period_ticks,
   input  logic [ptts_pkg::TIME_W-1:0]         req_deadline_ticks,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_load_ack,
   output logic                                rsp_busy_res,
   output logic [ptts_pkg::INDEX_W-1:0]        rsp_running_task
);
   import ptts_pkg::*;

   localparam int CFG_W = 3 * TIME_W;
   localparam logic signed [DL_W-1:0] DL_FLOOR =
      -$signed({{(DL_W-TICK_BITS-1){1'b0}}, 1'b1, {TICK_BITS{1'b0}}});
   localparam logic signed [DL_W-1:0] DL_ONE = DL_W'(1);

   // configuration registers
   logic policy_ff;
   logic [CSR_DATA_W-1:0] active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RM;
         active_ff <= CSR_DATA_W'(1);
      end else if (csr_write) begin
         if (csr_index == CSR_POLICY) begin
            policy_ff <= csr_wdata[0];
         end else if (csr_index == CSR_ACTIVE) begin
            active_ff <= csr_wdata;
         end
      end
   end

   assign n_active = (int'(active_ff) > TASKS) ? CNT_W'(TASKS) : CNT_W'(active_ff);

   // task memories
   logic [CFG_W-1:0] cfg_mem [TASKS];
   logic [TIME_W-1:0] work_mem [TASKS];
   logic [TIME_W-1:0] phase_mem [TASKS];
   logic signed [DL_W-1:0] dl_mem [TASKS];

   logic [CFG_W-1:0] cfg_rd_ff;
   logic [TIME_W-1:0] work_rd_ff, phase_rd_ff;
   logic signed [DL_W-1:0] dl_rd_ff;
   logic [IDX_W-1:0] eval_idx_ff;

   // entry flags: unwritten config reads as reset, fresh entries restart at zero
   logic [TASKS-1:0] cfg_vld_ff, cfg_vld_in;
   logic [TASKS-1:0] fresh_ff, fresh_in;
   logic [TASKS-1:0] dl_vld_ff, dl_vld_in;

   logic load_in_range;
   logic [IDX_W-1:0] load_addr;

   assign load_in_range = int'(req_task_index) < TASKS;
   assign load_addr = IDX_W'(req_task_index);

   // per-entry evaluation
   logic [TIME_W-1:0] e_exec, e_per, e_rel, e_work, e_phase, work_r;
   logic signed [DL_W-1:0] e_dl, dl_r, dl_nx;
   logic [TIME_W:0] phase_inc;
   logic [TIME_W-1:0] phase_nx;
   logic released, take;

   // best candidate so far
   logic found_ff, found_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic [TIME_W-1:0] best_work_ff, best_work_in, best_per_ff, best_per_in;
   logic signed [DL_W-1:0] best_dl_ff, best_dl_in;

   always_comb begin
      if (cfg_vld_ff[eval_idx_ff]) begin
         e_exec = cfg_rd_ff[CFG_W-1 -: TIME_W];
         e_per = cfg_rd_ff[2*TIME_W-1 -: TIME_W];
         e_rel = cfg_rd_ff[TIME_W-1:0];
      end else begin
         e_exec = '0;
         e_per = TIME_W'(1);
         e_rel = TIME_W'(1);
      end
      e_work = fresh_ff[eval_idx_ff] ? '0 : work_rd_ff;
      e_phase = fresh_ff[eval_idx_ff] ? '0 : phase_rd_ff;
      e_dl = dl_vld_ff[eval_idx_ff] ? dl_rd_ff : '0;

      released = e_phase == '0;
      work_r = released ? e_exec : e_work;
      dl_r = released ? $signed({{(DL_W-TIME_W){1'b0}}, e_rel}) : e_dl;

      phase_inc = {1'b0, e_phase} + (TIME_W+1)'(1);
      phase_nx = (phase_inc >= {1'b0, e_per}) ? '0 : phase_inc[TIME_W-1:0];
      dl_nx = (dl_r == DL_FLOOR) ? DL_FLOOR : dl_r - DL_ONE;

      // strict compare keeps the lowest index on equal keys
      take = (work_r != '0) &&
             (!found_ff || ((policy_ff == POLICY_EDF) ? (dl_r < best_dl_ff)
                                                      : (e_per < best_per_ff)));
   end

   always_comb begin
      found_in = found_ff;
      sel_in = sel_ff;
      best_work_in = best_work_ff;
      best_per_in = best_per_ff;
      best_dl_in = best_dl_ff;
      if (cmd.tick_start) begin
         found_in = 1'b0;
         sel_in = '0;
      end else if (cmd.eval && take) begin
         found_in = 1'b1;
         sel_in = eval_idx_ff;
         best_work_in = work_r;
         best_per_in = e_per;
         best_dl_in = dl_r;
      end
   end

   always_comb begin
      cfg_vld_in = cfg_vld_ff;
      fresh_in = fresh_ff;
      dl_vld_in = dl_vld_ff;
      if (cmd.load) begin
         fresh_in = '1;
         if (load_in_range) begin
            cfg_vld_in[load_addr] = 1'b1;
         end
      end
      if (cmd.eval) begin
         fresh_in[eval_idx_ff] = 1'b0;
         dl_vld_in[eval_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_vld_ff <= '0;
         fresh_ff <= '1;
         dl_vld_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         cfg_vld_ff <= cfg_vld_in;
         fresh_ff <= fresh_in;
         dl_vld_ff <= dl_vld_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      best_work_ff <= best_work_in;
      best_per_ff <= best_per_in;
      best_dl_ff <= best_dl_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         cfg_rd_ff <= cfg_mem[rd_idx];
         work_rd_ff <= work_mem[rd_idx];
         phase_rd_ff <= phase_mem[rd_idx];
         dl_rd_ff <= dl_mem[rd_idx];
         eval_idx_ff <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_in_range) begin
         cfg_mem[load_addr] <= {req_exec_time, req_period_ticks, req_deadline_ticks};
      end
   end

   // finish charges one tick of work to the granted entry
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         work_mem[eval_idx_ff] <= work_r;
      end else if (cmd.finish && found_ff) begin
         work_mem[sel_ff] <= best_work_ff - TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         phase_mem[eval_idx_ff] <= phase_nx;
         dl_mem[eval_idx_ff] <= dl_nx;
      end
   end

   // result register
   logic req_load_ff;
   logic rsp_valid_ff, rsp_load_ff, rsp_busy_ff;
   logic [INDEX_W-1:0] rsp_task_ff;

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.tick_start) begin
         req_load_ff <= cmd.load;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.req_load = req_type == REQ_LOAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_load_ff <= req_load_ff;
         rsp_busy_ff <= !req_load_ff && found_ff;
         rsp_task_ff <= (!req_load_ff && found_ff) ? INDEX_W'(sel_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_load_ack = rsp_load_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_running_task = rsp_task_ff;

endmodule
